FILE: sv/hhkb_pkg.sv
// Shared types and constants for the hue histogram k-th bin selector.
package hhkb_pkg;

    localparam int DEF_NUM_BINS    = 30;
    localparam int DEF_HUE_RANGE   = 180;
    localparam int DEF_COUNT_WIDTH = 16;

    localparam int HUE_W   = 8;
    localparam int RANK_W  = 4;
    localparam int BIN_W   = 5;

    localparam logic [RANK_W-1:0] RANK_RESET = 4'd3;

    typedef struct packed {
        logic [HUE_W-1:0] hue;
        logic             stripe_end;
    } t_in_item;

    typedef struct packed {
        logic [BIN_W-1:0] bin_index;
        logic             count_saturated;
    } t_result;

    typedef enum logic [2:0] {
        S_IDLE,
        S_BIN,
        S_UPD,
        S_SCAN,
        S_DRAIN
    } t_state;

endpackage

FILE: sv/hue_histogram_kth_bin.sv
// Hue histogram with selection of the bin at a chosen rank of population.
//
// A word is taken when i_start is high and o_busy is low; o_busy then stays high until the
// word is fully handled. An ordinary pixel is handled in steps: the bin number is formed by a
// reciprocal multiplication, then the bin count is read from the count memory and written
// back. On a pixel marked as the stripe end the block then ranks the bins with a single
// comparator that walks the count memory once for each rank up to k, where k is the requested
// rank limited to 1..NUM_BINS. The result appears on o_result for exactly one cycle, marked
// by o_result_valid, and must be taken then: there is no way to hold it off. Bins and the
// saturation flag are cleared at once when the result is produced. The rank register may be
// written at any time while the block is not busy.
module hue_histogram_kth_bin
    import hhkb_pkg::*;
#(
    parameter int NUM_BINS    = DEF_NUM_BINS,
    parameter int HUE_RANGE   = DEF_HUE_RANGE,
    parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  t_in_item          i_item,
    output logic              o_busy,
    output logic              o_result_valid,
    output t_result           o_result,
    input  logic              i_cfg_wr_en,
    input  logic [RANK_W-1:0] i_cfg_wr_data
);

    localparam int IDX_W  = $clog2(NUM_BINS);
    localparam int PASS_W = $clog2(NUM_BINS + 1);
    localparam int NB_W   = $clog2(NUM_BINS + 1);
    localparam int PROD_W = HUE_W + NB_W;
    // Shift chosen so that the rounded-up reciprocal gives the exact quotient for every product.
    localparam int SHIFT  = PROD_W + 8;
    localparam longint RECIP_L = ((64'd1 << SHIFT) + HUE_RANGE - 1) / HUE_RANGE;
    localparam logic [SHIFT-1:0] RECIP = SHIFT'(RECIP_L);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BINS - 1);

    t_state r_state, n_state;

    logic [RANK_W-1:0]      r_rank;
    logic [PROD_W+SHIFT-1:0] r_prod;
    logic                   r_last;
    logic [IDX_W-1:0]       r_bin;
    logic                   r_sat;

    logic [COUNT_WIDTH-1:0] r_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    r_valid;
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic                   r_rd_valid;

    logic [IDX_W-1:0]       r_scan_idx;
    logic [IDX_W-1:0]       r_cmp_idx;
    logic                   r_cmp_en;
    logic [PASS_W-1:0]      r_pass;
    logic                   r_have_prev;
    logic [COUNT_WIDTH-1:0] r_prev_cnt;
    logic [IDX_W-1:0]       r_prev_idx;
    logic                   r_have_best;
    logic [COUNT_WIDTH-1:0] r_best_cnt;
    logic [IDX_W-1:0]       r_best_idx;

    logic                   r_res_valid;
    t_result                r_result;

    logic [PROD_W-1:0]      quot;
    logic [IDX_W-1:0]       bin_calc;
    logic [IDX_W-1:0]       rd_addr;
    logic [COUNT_WIDTH-1:0] cnt_rd;
    logic                   cnt_wr;
    logic                   cmp_do;
    logic                   pass_done;
    logic                   finish;
    logic                   accept;
    logic [PASS_W-1:0]      k_eff;
    logic                   eligible;
    logic                   better;
    logic                   take;
    logic [COUNT_WIDTH-1:0] n_best_cnt;
    logic [IDX_W-1:0]       n_best_idx;

    assign accept = i_start && (r_state == S_IDLE);

    // Bin number from the registered product, with out-of-range hues folded into the last bin.
    always_comb begin
        quot = PROD_W'(r_prod >> SHIFT);
        if (quot >= PROD_W'(NUM_BINS)) begin
            bin_calc = LAST_IDX;
        end else begin
            bin_calc = IDX_W'(quot);
        end
    end

    always_comb begin
        if (r_rank == '0) begin
            k_eff = PASS_W'(1);
        end else if (32'(r_rank) > NUM_BINS) begin
            k_eff = PASS_W'(NUM_BINS);
        end else begin
            k_eff = PASS_W'(r_rank);
        end
    end

    assign cnt_rd = r_rd_valid ? r_rd_data : '0;

    // A bin qualifies in this pass if it comes after the previous pick in the ranking order;
    // scanning upwards, a strictly larger count is needed to displace the current best.
    always_comb begin
        eligible = !r_have_prev || (cnt_rd < r_prev_cnt) ||
                   ((cnt_rd == r_prev_cnt) && (r_cmp_idx > r_prev_idx));
        better   = !r_have_best || (cnt_rd > r_best_cnt);
        take     = cmp_do && eligible && better;
        n_best_cnt = take ? cnt_rd : r_best_cnt;
        n_best_idx = take ? r_cmp_idx : r_best_idx;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_BIN;
                end
            end
            S_BIN:   n_state = S_UPD;
            S_UPD:   n_state = r_last ? S_SCAN : S_IDLE;
            S_SCAN: begin
                if (r_scan_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: n_state = (r_pass == k_eff) ? S_IDLE : S_SCAN;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        rd_addr   = r_bin;
        cnt_wr    = 1'b0;
        cmp_do    = 1'b0;
        pass_done = 1'b0;
        unique case (r_state)
            S_IDLE: ;
            S_BIN:  rd_addr = bin_calc;
            S_UPD:  cnt_wr  = (cnt_rd != COUNT_MAX);
            S_SCAN: begin
                rd_addr = r_scan_idx;
                cmp_do  = r_cmp_en;
            end
            S_DRAIN: begin
                cmp_do    = r_cmp_en;
                pass_done = 1'b1;
            end
            default: ;
        endcase
        finish = pass_done && (r_pass == k_eff);
    end

    // Count memory: one write and one registered read a cycle.
    always_ff @(posedge i_clk) begin
        if (cnt_wr) begin
            r_mem[r_bin] <= cnt_rd + 1'b1;
        end
        r_rd_data  <= r_mem[rd_addr];
        r_rd_valid <= r_valid[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rank      <= RANK_RESET;
            r_valid     <= '0;
            r_sat       <= 1'b0;
            r_cmp_en    <= 1'b0;
            r_res_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmp_en    <= (r_state == S_SCAN);
            r_res_valid <= finish;
            if (i_cfg_wr_en) begin
                r_rank <= i_cfg_wr_data;
            end
            if (cnt_wr) begin
                r_valid[r_bin] <= 1'b1;
            end
            if ((r_state == S_UPD) && !cnt_wr) begin
                r_sat <= 1'b1;
            end
            if (finish) begin
                r_valid <= '0;
                r_sat   <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_prod <= (PROD_W+SHIFT)'(PROD_W'(i_item.hue) * PROD_W'(NUM_BINS)) *
                      (PROD_W+SHIFT)'(RECIP);
            r_last <= i_item.stripe_end;
        end
        if (r_state == S_BIN) begin
            r_bin <= bin_calc;
        end
        if (r_state == S_SCAN) begin
            r_scan_idx <= r_scan_idx + 1'b1;
            r_cmp_idx  <= r_scan_idx;
        end
        r_best_cnt <= n_best_cnt;
        r_best_idx <= n_best_idx;
        if (take && !pass_done) begin
            r_have_best <= 1'b1;
        end
        if ((r_state == S_UPD) && r_last) begin
            r_pass      <= PASS_W'(1);
            r_have_prev <= 1'b0;
            r_have_best <= 1'b0;
            r_scan_idx  <= '0;
        end
        if (pass_done) begin
            r_prev_cnt  <= n_best_cnt;
            r_prev_idx  <= n_best_idx;
            r_have_prev <= 1'b1;
            r_have_best <= 1'b0;
            r_scan_idx  <= '0;
            r_pass      <= r_pass + 1'b1;
        end
        if (finish) begin
            r_result.bin_index       <= BIN_W'(n_best_idx);
            r_result.count_saturated <= r_sat;
        end
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_result_valid = r_res_valid;
    assign o_result       = r_result;

endmodule

FILE: bench/hue_histogram_kth_bin_test.sv
// Self-checking testbench for the hue histogram k-th bin selector.
module hue_histogram_kth_bin_test;
    import hhkb_pkg::*;

    localparam int NBINS       = DEF_NUM_BINS;
    localparam int HRANGE      = DEF_HUE_RANGE;
    localparam int CW          = DEF_COUNT_WIDTH;
    localparam int PHASE_WORDS = 350;
    // Longest ranking pass with a margin, used before touching the rank register.
    localparam int SETTLE_CYCLES = 3 + 16 * (NBINS + 1) + 20;
    localparam int CYCLE_LIMIT   = 5_000_000;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_start = 1'b0;
    t_in_item          i_item = '0;
    logic              o_busy;
    logic              o_result_valid;
    t_result           o_result;
    logic              i_cfg_wr_en = 1'b0;
    logic [RANK_W-1:0] i_cfg_wr_data = '0;

    hue_histogram_kth_bin dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_start        (i_start),
        .i_item         (i_item),
        .o_busy         (o_busy),
        .o_result_valid (o_result_valid),
        .o_result       (o_result),
        .i_cfg_wr_en    (i_cfg_wr_en),
        .i_cfg_wr_data  (i_cfg_wr_data)
    );

    always #5 i_clk = ~i_clk;

    t_in_item          pixel_q[$];
    t_result           expected_bins[$];
    logic [CW-1:0]     bin_tally[NBINS];
    logic              tally_saturated = 1'b0;
    logic [RANK_W-1:0] rank_setting = RANK_RESET;
    int                err_count = 0;
    int                idle_left = 0;
    bit                burst = 1'b0;
    longint            cycle_count = 0;

    initial begin
        for (int i = 0; i < NBINS; i++) begin
            bin_tally[i] = '0;
        end
    end

    // Bin whose position in the descending order of counts equals the rank;
    // equal counts are ordered by lower bin index first.
    function automatic logic [BIN_W-1:0] kth_bin(input logic [RANK_W-1:0] rank);
        int k;
        int pos;
        logic [BIN_W-1:0] pick;
        k = (rank == 0) ? 1 : int'(rank);
        if (k > NBINS) k = NBINS;
        pick = '0;
        for (int i = 0; i < NBINS; i++) begin
            pos = 1;
            for (int j = 0; j < NBINS; j++) begin
                if (bin_tally[j] > bin_tally[i] || (bin_tally[j] == bin_tally[i] && j < i))
                    pos++;
            end
            if (pos == k) pick = BIN_W'(i);
        end
        return pick;
    endfunction

    function automatic void tally_pixel(input t_in_item word);
        int b;
        t_result res;
        b = (int'(word.hue) * NBINS) / HRANGE;
        if (b >= NBINS) b = NBINS - 1;
        if (bin_tally[b] == {CW{1'b1}})
            tally_saturated = 1'b1;
        else
            bin_tally[b] = bin_tally[b] + 1'b1;
        if (word.stripe_end) begin
            res.bin_index = kth_bin(rank_setting);
            res.count_saturated = tally_saturated;
            expected_bins.push_back(res);
            for (int i = 0; i < NBINS; i++) begin
                bin_tally[i] = '0;
            end
            tally_saturated = 1'b0;
        end
    endfunction

    // Gaps are counted only while the block is idle, so that they are seen by it.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_start <= 1'b0;
        end else if (i_start && !o_busy) begin
            tally_pixel(i_item);
            if (idle_left == 0 && pixel_q.size() != 0) begin
                i_item <= pixel_q.pop_front();
                i_start <= 1'b1;
                idle_left = burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0) burst = !burst;
            end else begin
                i_start <= 1'b0;
            end
        end else if (!i_start) begin
            if (idle_left > 0) begin
                if (!o_busy) idle_left--;
            end else if (pixel_q.size() != 0) begin
                i_item <= pixel_q.pop_front();
                i_start <= 1'b1;
                idle_left = burst ? 0 : $urandom_range(0, 3);
                if ($urandom_range(0, 63) == 0) burst = !burst;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (expected_bins.size() == 0) begin
                $error("unexpected result: bin_index %0d, count_saturated %0d",
                       o_result.bin_index, o_result.count_saturated);
                err_count++;
            end else begin
                t_result want;
                want = expected_bins.pop_front();
                if (o_result.bin_index !== want.bin_index) begin
                    $error("bin_index: expected %0d, got %0d",
                           want.bin_index, o_result.bin_index);
                    err_count++;
                end
                if (o_result.count_saturated !== want.count_saturated) begin
                    $error("count_saturated: expected %0d, got %0d",
                           want.count_saturated, o_result.count_saturated);
                    err_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic add_pixel(input int hue, input bit last);
        t_in_item word;
        word.hue = HUE_W'(hue);
        word.stripe_end = last;
        pixel_q.push_back(word);
    endtask

    // Mostly stripes built around a few favoured hues, so that the ranks are well
    // separated; now and then one pixel per bin, which makes every count equal.
    task automatic add_stripe(output int words);
        int kind;
        int len;
        int off;
        int fav[4];
        kind = $urandom_range(0, 9);
        if (kind == 0) begin
            off = $urandom_range(0, NBINS - 1);
            for (int i = 0; i < NBINS; i++) begin
                add_pixel(((off + i) % NBINS) * (HRANGE / NBINS) + $urandom_range(0, 5),
                          i == NBINS - 1);
            end
            words = NBINS;
        end else begin
            len = (kind < 3) ? $urandom_range(1, 80) : $urandom_range(1, 20);
            foreach (fav[i]) fav[i] = $urandom_range(0, 255);
            for (int i = 0; i < len; i++) begin
                if ($urandom_range(0, 9) < 7)
                    add_pixel(fav[$urandom_range(0, 3)], i == len - 1);
                else
                    add_pixel($urandom_range(0, 255), i == len - 1);
            end
            words = len;
        end
    endtask

    task automatic wait_idle();
        while (pixel_q.size() != 0 || i_start || expected_bins.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
    endtask

    task automatic write_rank(input logic [RANK_W-1:0] rank);
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= rank;
        rank_setting = rank;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    task automatic random_phase();
        int total;
        int n;
        total = 0;
        while (total < PHASE_WORDS) begin
            add_stripe(n);
            total += n;
        end
    endtask

    initial begin
        logic [RANK_W-1:0] ranks[5];
        ranks = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd0};
        ranks[4] = RANK_W'($urandom_range(0, 15));

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed stripes at the reset rank: a lone pixel, hues at and beyond the
        // top of the range, bin boundaries, tied counts and a walk over the hue bits.
        add_pixel(0, 1'b1);
        add_pixel(179, 1'b0);
        add_pixel(180, 1'b0);
        add_pixel(255, 1'b0);
        add_pixel(5, 1'b0);
        add_pixel(6, 1'b1);
        add_pixel(100, 1'b0);
        add_pixel(100, 1'b0);
        add_pixel(50, 1'b0);
        add_pixel(50, 1'b0);
        add_pixel(10, 1'b0);
        add_pixel(10, 1'b0);
        add_pixel(10, 1'b1);
        add_pixel(170, 1'b0);
        add_pixel(174, 1'b0);
        add_pixel(128, 1'b0);
        add_pixel(64, 1'b0);
        add_pixel(32, 1'b0);
        add_pixel(16, 1'b0);
        add_pixel(8, 1'b0);
        add_pixel(4, 1'b0);
        add_pixel(2, 1'b0);
        add_pixel(1, 1'b1);
        wait_idle();

        for (int p = 0; p < 5; p++) begin
            write_rank(ranks[p]);
            random_phase();
            wait_idle();
            if (p == 1) begin
                // One bin filled to its maximum, so that the final word saturates it.
                write_rank(4'd1);
                for (int i = 0; i < (1 << CW) - 1; i++) begin
                    add_pixel(90 + i % 6, 1'b0);
                end
                add_pixel(95, 1'b1);
                wait_idle();
            end
        end

        if (expected_bins.size() != 0) begin
            $error("%0d expected results never arrived", expected_bins.size());
            err_count++;
        end
        if (err_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

FILE: files.f
sv/hhkb_pkg.sv
sv/hue_histogram_kth_bin.sv
bench/hue_histogram_kth_bin_test.sv
